/* src/egcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg: shared types and helpers for the extended GCD block
// Holds the datapath width, the word type, the request/response bundles of
// the shared divide/multiply unit and small sign helpers.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // Port payloads are fixed at 64 bits; arithmetic runs at WIDTH bits.
  localparam int IO_W  = 64;
  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request into the shared unit: start one magnitude division and, on the
  // same quotient bits, the products quotient*mx and quotient*my.
  typedef struct packed {
    logic  start;
    word_t dvd;
    word_t dvs;
    word_t mx;
    word_t my;
  } egcd_unit_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
    word_t prod_x;
    word_t prod_y;
  } egcd_unit_rsp_t;

  function automatic word_t mag(input word_t v);
    return v[WIDTH-1] ? word_t'(-v) : v;
  endfunction

  function automatic logic signed [IO_W-1:0] sext(input word_t v);
    return IO_W'($signed(v));
  endfunction

endpackage
`default_nettype wire

/* src/egcd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_if: request and result channels of the extended GCD block
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface egcd_in_if import egcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] n;
  logic signed [IO_W-1:0] e;

  modport source (output valid, output n, output e, input ready);
  modport sink   (input valid, input n, input e, output ready);
endinterface

interface egcd_out_if import egcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] gcd;
  logic signed [IO_W-1:0] coef_n;
  logic signed [IO_W-1:0] coef_e;
  logic                   zero_operand;

  modport source (output valid, output gcd, output coef_n, output coef_e,
                  output zero_operand, input ready);
  modport sink   (input valid, input gcd, input coef_n, input coef_e,
                  input zero_operand, output ready);
endinterface
`default_nettype wire

/* src/extended_gcd_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_top: extended Euclidean algorithm on signed operands
// Orders n and e by magnitude, then repeats truncating division on a shared
// bit-serial unit while carrying the Bezout coefficients.
//
//   channel  | dir | payload                              | handshake
//   in_i     | in  | n, e                                 | valid/ready
//   out_o    | out | gcd, coef_n, coef_e, zero_operand    | valid/ready
//
// A request runs one division per quotient step (at most about 93 steps for
// 64-bit operands); a zero divisor skips division and goes straight to done.
// The bit-serial divider produces one quotient bit per cycle.
// in_i.ready is high only while idle; the output register holds a result
// until taken, and a finished request waits for it to free up.
// Reset is asynchronous and active low and clears all control state.
// ----------------------------------------------------------------------------
module extended_gcd_top import egcd_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  egcd_in_if.sink    in_i,
  egcd_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  word_t a0_q, a_q, x0_q, x_q, y0_q, y_q;
  logic  nbig_q, zero_q;
  logic  out_valid_q;
  logic signed [IO_W-1:0] gcd_q, coef_n_q, coef_e_q;
  logic  zflag_q;

  egcd_unit_req_t unit_req;
  egcd_unit_rsp_t unit_rsp;

  word_t n_w, e_w, mag_n, mag_e, sel_a0, sel_a;
  logic  n_big;
  word_t r_w, x_nx, y_nx;
  logic  q_neg;
  logic  accept, finish, step, out_load;

  egcd_divmac u_divmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  always_comb begin
    n_w    = in_i.n[WIDTH-1:0];
    e_w    = in_i.e[WIDTH-1:0];
    mag_n  = mag(n_w);
    mag_e  = mag(e_w);
    n_big  = mag_n >= mag_e;
    sel_a0 = n_big ? n_w : e_w;
    sel_a  = n_big ? e_w : n_w;

    q_neg  = a0_q[WIDTH-1] ^ a_q[WIDTH-1];
    r_w    = a0_q[WIDTH-1] ? word_t'(-unit_rsp.rem) : unit_rsp.rem;
    x_nx   = q_neg ? x0_q + unit_rsp.prod_x : x0_q - unit_rsp.prod_x;
    y_nx   = q_neg ? y0_q + unit_rsp.prod_y : y0_q - unit_rsp.prod_y;

    accept   = in_i.valid && (state_q == ST_IDLE);
    finish   = (state_q == ST_DIV) && unit_rsp.done && (r_w == '0);
    step     = (state_q == ST_DIV) && unit_rsp.done && (r_w != '0);
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

    unit_req.start = (accept && sel_a != '0) || step;
    unit_req.dvd   = (state_q == ST_IDLE) ? mag(sel_a0) : mag(a_q);
    unit_req.dvs   = (state_q == ST_IDLE) ? mag(sel_a) : unit_rsp.rem;
    unit_req.mx    = (state_q == ST_IDLE) ? '0 : x_nx;
    unit_req.my    = (state_q == ST_IDLE) ? word_t'(1) : y_nx;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = (sel_a == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (finish) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a0_q   <= sel_a0;
      a_q    <= sel_a;
      x0_q   <= word_t'(1);
      x_q    <= '0;
      y0_q   <= '0;
      y_q    <= word_t'(1);
      nbig_q <= n_big;
      zero_q <= (sel_a == '0);
    end else if (step) begin
      // advance one Euclid step: shift the remainder and coefficient pairs
      a0_q <= a_q;
      a_q  <= r_w;
      x0_q <= x_q;
      x_q  <= x_nx;
      y0_q <= y_q;
      y_q  <= y_nx;
    end
    if (out_load) begin
      gcd_q    <= zero_q ? '0 : sext(a_q);
      coef_n_q <= zero_q ? '0 : sext(nbig_q ? x_q : y_q);
      coef_e_q <= zero_q ? '0 : sext(nbig_q ? y_q : x_q);
      zflag_q  <= zero_q;
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.gcd          = gcd_q;
  assign out_o.coef_n       = coef_n_q;
  assign out_o.coef_e       = coef_e_q;
  assign out_o.zero_operand = zflag_q;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside of a division step");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> a_q != '0)
    else $error("division running with a zero divisor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request taken while a previous one is in flight");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_operand |->
      out_o.gcd == '0 && out_o.coef_n == '0 && out_o.coef_e == '0)
    else $error("zero operand result carries nonzero fields");
`endif

endmodule
`default_nettype wire

/* src/egcd_divmac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_divmac: shared bit-serial divide and multiply-accumulate unit
// Restoring division of two magnitudes, one quotient bit per cycle, MSB
// first. Each quotient bit also feeds two Horner accumulators that build
// quotient*mx and quotient*my modulo 2^WIDTH.
// ----------------------------------------------------------------------------
module egcd_divmac import egcd_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  egcd_unit_req_t req_i,
  output egcd_unit_rsp_t rsp_o
);

  logic  busy_q;
  logic  done_q;
  cnt_t  cnt_q;
  word_t rem_q, quo_q, dvs_q, mx_q, my_q, acc_x_q, acc_y_q;

  logic [WIDTH:0] trial;
  logic           qbit;

  always_comb begin
    trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dvs_q};
    qbit  = ~trial[WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cnt_t'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - cnt_t'(1);
        if (cnt_q == cnt_t'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q   <= '0;
      quo_q   <= req_i.dvd;
      dvs_q   <= req_i.dvs;
      mx_q    <= req_i.mx;
      my_q    <= req_i.my;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (busy_q) begin
      // keep the partial remainder when the trial subtract goes negative
      rem_q   <= qbit ? trial[WIDTH-1:0] : {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
      quo_q   <= {quo_q[WIDTH-2:0], qbit};
      acc_x_q <= {acc_x_q[WIDTH-2:0], 1'b0} + (qbit ? mx_q : '0);
      acc_y_q <= {acc_y_q[WIDTH-2:0], 1'b0} + (qbit ? my_q : '0);
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem    = rem_q;
  assign rsp_o.prod_x = acc_x_q;
  assign rsp_o.prod_y = acc_y_q;

endmodule
`default_nettype wire

/* tb/egcd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_checker: scoreboard for the extended GCD block
// Watches the request and result channels. For each accepted request it
// computes the gcd and Bezout coefficients on its own and queues them; each
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module egcd_checker import egcd_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  egcd_in_if   req_if,
  egcd_out_if  res_if,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output int   zero_cnt_o
);

  typedef struct {
    logic signed [IO_W-1:0] gcd;
    logic signed [IO_W-1:0] coef_n;
    logic signed [IO_W-1:0] coef_e;
    logic                   zero_operand;
  } bezout_t;

  bezout_t pending_bezout[$];
  int      fails    = 0;
  int      checked  = 0;
  int      zeros    = 0;
  int      inflight = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = inflight;
  assign checked_o  = checked;
  assign zero_cnt_o = zeros;

  // Unsigned magnitude; the most negative value maps to 2^(WIDTH-1).
  function automatic word_t abs_w(input word_t v);
    return v[WIDTH-1] ? word_t'(0 - v) : v;
  endfunction

  function automatic word_t trunc_div(input word_t num, input word_t den);
    word_t q;
    q = abs_w(num) / abs_w(den);
    return (num[WIDTH-1] ^ den[WIDTH-1]) ? word_t'(0 - q) : q;
  endfunction

  function automatic logic signed [IO_W-1:0] widen(input word_t v);
    return $signed(v);
  endfunction

  function automatic bezout_t solve_bezout(input logic [IO_W-1:0] n_in,
                                           input logic [IO_W-1:0] e_in);
    bezout_t res;
    word_t   n, e, big, sml, q, r, x0, x, y0, y, t;
    logic    n_big;
    n     = n_in[WIDTH-1:0];
    e     = e_in[WIDTH-1:0];
    n_big = abs_w(n) >= abs_w(e);
    big   = n_big ? n : e;
    sml   = n_big ? e : n;
    x0 = 1; y0 = 0; x = 0; y = 1;
    if (sml == '0) begin
      res.gcd = '0; res.coef_n = '0; res.coef_e = '0; res.zero_operand = 1'b1;
      return res;
    end
    q = trunc_div(big, sml);
    r = big - sml * q;
    while (r != '0) begin
      big = sml;
      sml = r;
      t = x0 - q * x; x0 = x; x = t;
      t = y0 - q * y; y0 = y; y = t;
      q = trunc_div(big, sml);
      r = big - sml * q;
    end
    res.gcd          = widen(sml);
    res.coef_n       = widen(n_big ? x : y);
    res.coef_e       = widen(n_big ? y : x);
    res.zero_operand = 1'b0;
    return res;
  endfunction

  task automatic check_field(input string field, input logic signed [IO_W-1:0] want,
                             input logic signed [IO_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bezout_t want;
    if (!rst_ni) begin
      pending_bezout.delete();
      inflight = 0;
    end else begin
      // Retire the result first: a new request may land on the same edge.
      if (res_if.valid && res_if.ready) begin
        checked++;
        if (res_if.zero_operand === 1'b1) zeros++;
        if (pending_bezout.size() == 0) begin
          $error("unexpected result: gcd %0d with no request outstanding", res_if.gcd);
          fails++;
        end else begin
          want = pending_bezout.pop_front();
          check_field("gcd", want.gcd, res_if.gcd);
          check_field("coef_n", want.coef_n, res_if.coef_n);
          check_field("coef_e", want.coef_e, res_if.coef_e);
          check_field("zero_operand", IO_W'(want.zero_operand), IO_W'(res_if.zero_operand));
        end
      end
      if (req_if.valid && req_if.ready)
        pending_bezout.push_back(solve_bezout(req_if.n, req_if.e));
      inflight = pending_bezout.size();
    end
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench for extended_gcd_top
// Sends directed corner pairs (zero divisors, most negative and largest
// values, ties, quotient overflow, long Fibonacci chains), then a random mix
// of small, full-width, common-factor and worst-case operand pairs, with
// random bursts of idle on both channels. A checker module scores results.
// ----------------------------------------------------------------------------
module tb;
  import egcd_pkg::*;

  localparam int NUM_ITEMS   = 1700;
  localparam int CALM_TAIL   = 150;
  localparam int QUIET_LIMIT = 40000;
  localparam int DRAIN_WAIT  = 64;

  localparam logic signed [IO_W-1:0] W_MIN =
    $signed({{(IO_W-WIDTH+1){1'b1}}, {(WIDTH-1){1'b0}}});
  localparam logic signed [IO_W-1:0] W_MAX = ~W_MIN;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  int   sent  = 0;
  int   fail_cnt, pending, checked, zero_cnt;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  logic signed [IO_W-1:0] fib [0:92];

  egcd_in_if  req_if ();
  egcd_out_if res_if ();

  extended_gcd_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  egcd_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_if     (req_if),
    .res_if     (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .zero_cnt_o (zero_cnt)
  );

  always #10 clk = ~clk;

  // Random value below 2^bits in magnitude, random sign.
  function automatic logic signed [IO_W-1:0] rand_mag(input int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom} >> (64 - bits);
    return $urandom_range(0, 1) ? -$signed(raw) : $signed(raw);
  endfunction

  task automatic send_pair(input logic signed [IO_W-1:0] n, input logic signed [IO_W-1:0] e);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.n     <= n;
    req_if.e     <= e;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Result side: stall in bursts of random length, none once calm.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 7);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [IO_W-1:0] a, b, g;
    int pick, k, deep;
    req_if.valid = 1'b0;
    req_if.n     = '0;
    req_if.e     = '0;
    res_if.ready = 1'b0;
    deep = 0;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 92; i++) fib[i] = fib[i-1] + fib[i-2];

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners.
    send_pair(0, 0);
    send_pair(0, 5);
    send_pair(-5, 0);
    send_pair(W_MIN, 0);
    send_pair(0, W_MAX);
    send_pair(W_MIN, -1);
    send_pair(-1, W_MIN);
    send_pair(W_MIN, W_MIN);
    send_pair(W_MAX, W_MIN);
    send_pair(W_MAX, W_MAX);
    send_pair(12, 18);
    send_pair(-12, 18);
    send_pair(12, -18);
    send_pair(-12, -18);
    send_pair(7, -7);
    send_pair(-7, 7);
    send_pair(fib[92], fib[91]);
    send_pair(-fib[91], fib[92]);
    send_pair(1, W_MAX);
    send_pair(W_MAX, -1);
    send_pair(W_MIN, 2);
    send_pair(W_MIN, -W_MAX);
    send_pair(-1, -1);
    send_pair(64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAB);

    while (sent < NUM_ITEMS) begin
      if (sent >= NUM_ITEMS - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        a = rand_mag($urandom_range(1, 16));
        b = rand_mag($urandom_range(1, 16));
      end else if (pick < 55) begin
        g = rand_mag($urandom_range(1, 12));
        a = g * rand_mag($urandom_range(1, 20));
        b = g * rand_mag($urandom_range(1, 20));
      end else if (pick < 67) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end else if (pick < 75) begin
        // Consecutive Fibonacci numbers: the longest quotient chains.
        k = $urandom_range(1, 91);
        a = $urandom_range(0, 1) ? -fib[k+1] : fib[k+1];
        b = $urandom_range(0, 1) ? -fib[k] : fib[k];
        if ($urandom_range(0, 1)) begin
          g = a; a = b; b = g;
        end
        deep++;
      end else if (pick < 83) begin
        a = $urandom_range(0, 1) ? {$urandom, $urandom} : rand_mag($urandom_range(1, 16));
        b = 0;
        if ($urandom_range(0, 3) == 0) a = 0;
        if ($urandom_range(0, 1)) begin
          g = a; a = b; b = g;
        end
      end else if (pick < 91) begin
        a = rand_mag($urandom_range(1, 63));
        b = $urandom_range(0, 1) ? -a : a;
      end else begin
        case ($urandom_range(0, 4))
          0: a = W_MIN;
          1: a = W_MAX;
          2: a = 1;
          3: a = -1;
          default: a = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 4))
          0: b = W_MIN;
          1: b = W_MAX;
          2: b = 1;
          3: b = -1;
          default: b = {$urandom, $urandom};
        endcase
      end
      send_pair(a, b);
    end

    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("summary: %0d operand pairs sent, %0d results checked, %0d with a zero divisor",
             sent, checked, zero_cnt);
    $display("summary: %0d random Fibonacci chains, idle bursts on both channels", deep);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
